### rtl/dldn_pkg.sv
// ----------------------------------------------------------------------------
// Delay line two-layer net package
// Shared constants, field widths, item kinds and the sequencer-to-MAC control
// word used by the delay line two-layer net.
// ----------------------------------------------------------------------------
package dldn_pkg;

    localparam int TAPS_DEF         = 16;
    localparam int HIDDEN_UNITS_DEF = 8;
    localparam int OUTPUT_UNITS_DEF = 2;
    localparam int FRAC_BITS_DEF    = 12;

    localparam int MODE_W      = 2;
    localparam int INDEX_W     = 7;
    localparam int SAMPLE_W    = 16;
    localparam int OUT_INDEX_W = 1;
    localparam int OUT_VALUE_W = 13;
    localparam int PROD_W      = 2 * SAMPLE_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_SAMPLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_W1_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_W2_WRITE = 2'd2;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic layer2;
        logic zero;
    } mac_ctrl_t;

endpackage

### rtl/dldn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dldn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/dldn_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Selects the operands, forms the scaled product and adds it into a running
// sum that is clamped to the range zero to one after every addition.
// ----------------------------------------------------------------------------
module dldn_mac #(
    parameter int FRAC_BITS = dldn_pkg::FRAC_BITS_DEF,
    parameter int UNIT_W    = 3,
    localparam int ACT_W    = FRAC_BITS + 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dldn_pkg::mac_ctrl_t            issue_ctrl,
    input  logic [UNIT_W-1:0]              issue_unit,
    input  logic [dldn_pkg::SAMPLE_W-1:0]  tap_data,
    input  logic [dldn_pkg::SAMPLE_W-1:0]  w1_data,
    input  logic [ACT_W-1:0]               hid_data,
    input  logic [dldn_pkg::SAMPLE_W-1:0]  w2_data,
    output logic                           busy,
    output logic                           result_valid,
    output logic                           result_layer2,
    output logic [UNIT_W-1:0]              result_unit,
    output logic [ACT_W-1:0]               result_value
);

    localparam int SUM_W = dldn_pkg::PROD_W + 1;
    localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(1) << FRAC_BITS;

    dldn_pkg::mac_ctrl_t ctrl_s1_reg;
    dldn_pkg::mac_ctrl_t ctrl_s2_reg;
    logic [UNIT_W-1:0]   unit_s1_reg;
    logic [UNIT_W-1:0]   unit_s2_reg;

    logic signed [dldn_pkg::SAMPLE_W-1:0] op_a;
    logic signed [dldn_pkg::SAMPLE_W-1:0] op_b;
    logic signed [dldn_pkg::PROD_W-1:0]   prod_full;
    logic signed [dldn_pkg::PROD_W-1:0]   prod_reg;
    logic [ACT_W-1:0]                     acc_reg;
    logic signed [SUM_W-1:0]              sum;
    logic [ACT_W-1:0]                     acc_next;

    always_comb begin
        if (ctrl_s1_reg.layer2) begin
            op_a = signed'(dldn_pkg::SAMPLE_W'(hid_data));
            op_b = signed'(w2_data);
        end else begin
            op_a = ctrl_s1_reg.zero ? '0 : signed'(tap_data);
            op_b = signed'(w1_data);
        end
        prod_full = op_a * op_b;
    end

    always_comb begin
        sum = (ctrl_s2_reg.first ? SUM_W'(0) : SUM_W'(acc_reg)) + SUM_W'(prod_reg);
        priority if (sum < 0) begin
            acc_next = '0;
        end else if (sum > ONE_Q) begin
            acc_next = ACT_W'(ONE_Q);
        end else begin
            acc_next = sum[ACT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_s1_reg <= '0;
            ctrl_s2_reg <= '0;
        end else begin
            ctrl_s1_reg <= issue_ctrl;
            ctrl_s2_reg <= ctrl_s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        unit_s1_reg <= issue_unit;
        unit_s2_reg <= unit_s1_reg;
        prod_reg    <= prod_full >>> FRAC_BITS;
        if (ctrl_s2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign busy          = ctrl_s1_reg.valid | ctrl_s2_reg.valid;
    assign result_valid  = ctrl_s2_reg.valid & ctrl_s2_reg.last;
    assign result_layer2 = ctrl_s2_reg.layer2;
    assign result_unit   = unit_s2_reg;
    assign result_value  = acc_next;

endmodule

### rtl/dldn_seq.sv
// ----------------------------------------------------------------------------
// Evaluation sequencer
// Keeps the delay line pointer and fill count, walks the weight, tap and hidden
// activation addresses of both layers, one product per cycle when not stalled.
// ----------------------------------------------------------------------------
module dldn_seq #(
    parameter int TAPS         = dldn_pkg::TAPS_DEF,
    parameter int HIDDEN_UNITS = dldn_pkg::HIDDEN_UNITS_DEF,
    parameter int OUTPUT_UNITS = dldn_pkg::OUTPUT_UNITS_DEF,
    localparam int TAP_AW   = (TAPS > 1) ? $clog2(TAPS) : 1,
    localparam int FILL_W   = $clog2(TAPS + 1),
    localparam int HID_AW   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1,
    localparam int OUT_AW   = (OUTPUT_UNITS > 1) ? $clog2(OUTPUT_UNITS) : 1,
    localparam int UNIT_W   = (HID_AW > OUT_AW) ? HID_AW : OUT_AW,
    localparam int W1_DEPTH = TAPS * HIDDEN_UNITS,
    localparam int W1_AW    = (W1_DEPTH > 1) ? $clog2(W1_DEPTH) : 1,
    localparam int W2_DEPTH = HIDDEN_UNITS * OUTPUT_UNITS,
    localparam int W2_AW    = (W2_DEPTH > 1) ? $clog2(W2_DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                mac_busy,
    input  logic                out_free,
    output logic                idle,
    output logic [TAP_AW-1:0]   tap_wr_addr,
    output logic [TAP_AW-1:0]   tap_rd_addr,
    output logic [W1_AW-1:0]    w1_rd_addr,
    output logic [HID_AW-1:0]   hid_rd_addr,
    output logic [W2_AW-1:0]    w2_rd_addr,
    output dldn_pkg::mac_ctrl_t issue_ctrl,
    output logic [UNIT_W-1:0]   issue_unit
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LAYER1  = 3'd1;
    localparam logic [2:0] ST_DRAIN1  = 3'd2;
    localparam logic [2:0] ST_WAIT2   = 3'd3;
    localparam logic [2:0] ST_LAYER2  = 3'd4;
    localparam logic [2:0] ST_DRAIN2  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [TAP_AW-1:0] wptr_reg, wptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [TAP_AW-1:0] tap_cnt_reg, tap_cnt_next;
    logic [TAP_AW-1:0] tap_addr_reg, tap_addr_next;
    logic [UNIT_W-1:0] unit_cnt_reg, unit_cnt_next;
    logic [HID_AW-1:0] hid_cnt_reg, hid_cnt_next;
    logic [W1_AW-1:0]  w1_addr_reg, w1_addr_next;
    logic [W2_AW-1:0]  w2_addr_reg, w2_addr_next;
    logic [TAP_AW-1:0] wptr_inc;
    logic              tap_last;
    logic              hid_last;

    assign wptr_inc = (wptr_reg == TAP_AW'(TAPS - 1)) ? '0 : wptr_reg + 1'b1;
    assign tap_last = (tap_cnt_reg == TAP_AW'(TAPS - 1));
    assign hid_last = (hid_cnt_reg == HID_AW'(HIDDEN_UNITS - 1));

    always_comb begin
        state_next    = state_reg;
        wptr_next     = wptr_reg;
        fill_next     = fill_reg;
        tap_cnt_next  = tap_cnt_reg;
        tap_addr_next = tap_addr_reg;
        unit_cnt_next = unit_cnt_reg;
        hid_cnt_next  = hid_cnt_reg;
        w1_addr_next  = w1_addr_reg;
        w2_addr_next  = w2_addr_reg;
        issue_ctrl    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    wptr_next     = wptr_inc;
                    fill_next     = (fill_reg == FILL_W'(TAPS)) ? fill_reg : fill_reg + 1'b1;
                    tap_cnt_next  = '0;
                    tap_addr_next = wptr_inc;
                    unit_cnt_next = '0;
                    w1_addr_next  = '0;
                    state_next    = ST_LAYER1;
                end
            end
            ST_LAYER1: begin
                issue_ctrl.valid  = 1'b1;
                issue_ctrl.first  = (tap_cnt_reg == '0);
                issue_ctrl.last   = tap_last;
                issue_ctrl.layer2 = 1'b0;
                issue_ctrl.zero   = !(FILL_W'(tap_cnt_reg) < fill_reg);
                if (tap_last) begin
                    tap_cnt_next  = '0;
                    tap_addr_next = wptr_reg;
                    unit_cnt_next = unit_cnt_reg + 1'b1;
                    w1_addr_next  = W1_AW'(unit_cnt_reg) + W1_AW'(1);
                    if (unit_cnt_reg == UNIT_W'(HIDDEN_UNITS - 1)) begin
                        state_next = ST_DRAIN1;
                    end
                end else begin
                    tap_cnt_next  = tap_cnt_reg + 1'b1;
                    tap_addr_next = (tap_addr_reg == '0) ? TAP_AW'(TAPS - 1)
                                                         : tap_addr_reg - 1'b1;
                    w1_addr_next  = w1_addr_reg + W1_AW'(HIDDEN_UNITS);
                end
            end
            ST_DRAIN1: begin
                if (!mac_busy) begin
                    unit_cnt_next = '0;
                    hid_cnt_next  = '0;
                    w2_addr_next  = '0;
                    state_next    = ST_WAIT2;
                end
            end
            ST_WAIT2: begin
                if (out_free) begin
                    state_next = ST_LAYER2;
                end
            end
            ST_LAYER2: begin
                issue_ctrl.valid  = 1'b1;
                issue_ctrl.first  = (hid_cnt_reg == '0);
                issue_ctrl.last   = hid_last;
                issue_ctrl.layer2 = 1'b1;
                issue_ctrl.zero   = 1'b0;
                if (hid_last) begin
                    hid_cnt_next = '0;
                    state_next   = ST_DRAIN2;
                end else begin
                    hid_cnt_next = hid_cnt_reg + 1'b1;
                    w2_addr_next = w2_addr_reg + W2_AW'(OUTPUT_UNITS);
                end
            end
            ST_DRAIN2: begin
                if (!mac_busy) begin
                    if (unit_cnt_reg == UNIT_W'(OUTPUT_UNITS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        unit_cnt_next = unit_cnt_reg + 1'b1;
                        w2_addr_next  = W2_AW'(unit_cnt_reg) + W2_AW'(1);
                        state_next    = ST_WAIT2;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wptr_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        tap_cnt_reg  <= tap_cnt_next;
        tap_addr_reg <= tap_addr_next;
        unit_cnt_reg <= unit_cnt_next;
        hid_cnt_reg  <= hid_cnt_next;
        w1_addr_reg  <= w1_addr_next;
        w2_addr_reg  <= w2_addr_next;
    end

    assign idle        = (state_reg == ST_IDLE);
    assign tap_wr_addr = wptr_inc;
    assign tap_rd_addr = tap_addr_reg;
    assign w1_rd_addr  = w1_addr_reg;
    assign hid_rd_addr = hid_cnt_reg;
    assign w2_rd_addr  = w2_addr_reg;
    assign issue_unit  = unit_cnt_reg;

endmodule

### rtl/delay_line_two_layer_net_unit.sv
// ----------------------------------------------------------------------------
// Delay line two-layer net
// All products go through the single shared MAC unit, which performs one product
// per cycle while the sequencer issues a layer; the sequencer stalls between passes
// to drain the MAC and to wait for a free output stage. A weight load gives no item.
// Reset clears the sequencer, the delay line fill count and the output stage; the
// delay line reads as zero until filled, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module delay_line_two_layer_net_unit #(
    parameter int TAPS         = dldn_pkg::TAPS_DEF,
    parameter int HIDDEN_UNITS = dldn_pkg::HIDDEN_UNITS_DEF,
    parameter int OUTPUT_UNITS = dldn_pkg::OUTPUT_UNITS_DEF,
    parameter int FRAC_BITS    = dldn_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // weight_index [6:0], data_value [22:7], zero padding above.
    input  logic [dldn_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode [1:0].
    input  logic [dldn_pkg::MODE_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // output_index [0], output_value [13:1], zero padding above.
    output logic [dldn_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);

    localparam int TAP_AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int HID_AW   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int OUT_AW   = (OUTPUT_UNITS > 1) ? $clog2(OUTPUT_UNITS) : 1;
    localparam int UNIT_W   = (HID_AW > OUT_AW) ? HID_AW : OUT_AW;
    localparam int W1_DEPTH = TAPS * HIDDEN_UNITS;
    localparam int W1_AW    = (W1_DEPTH > 1) ? $clog2(W1_DEPTH) : 1;
    localparam int W2_DEPTH = HIDDEN_UNITS * OUTPUT_UNITS;
    localparam int W2_AW    = (W2_DEPTH > 1) ? $clog2(W2_DEPTH) : 1;
    localparam int ACT_W    = FRAC_BITS + 1;

    logic                                 accept;
    logic [dldn_pkg::MODE_W-1:0]          mode;
    logic [dldn_pkg::INDEX_W-1:0]         weight_index;
    logic [dldn_pkg::SAMPLE_W-1:0]        data_value;
    logic                                 start;
    logic                                 w1_wr_en;
    logic                                 w2_wr_en;
    logic                                 hid_wr_en;

    logic                                 idle;
    logic                                 mac_busy;
    logic                                 out_free;
    logic [TAP_AW-1:0]                    tap_wr_addr;
    logic [TAP_AW-1:0]                    tap_rd_addr;
    logic [W1_AW-1:0]                     w1_rd_addr;
    logic [HID_AW-1:0]                    hid_rd_addr;
    logic [W2_AW-1:0]                     w2_rd_addr;
    dldn_pkg::mac_ctrl_t                  issue_ctrl;
    logic [UNIT_W-1:0]                    issue_unit;

    logic [dldn_pkg::SAMPLE_W-1:0]        tap_data;
    logic [dldn_pkg::SAMPLE_W-1:0]        w1_data;
    logic [ACT_W-1:0]                     hid_data;
    logic [dldn_pkg::SAMPLE_W-1:0]        w2_data;

    logic                                 result_valid;
    logic                                 result_layer2;
    logic [UNIT_W-1:0]                    result_unit;
    logic [ACT_W-1:0]                     result_value;

    logic                                 out_valid_reg;
    logic [dldn_pkg::OUT_INDEX_W-1:0]     out_index_reg;
    logic [dldn_pkg::OUT_VALUE_W-1:0]     out_value_reg;
    logic                                 out_last_reg;
    logic                                 out_load;

    assign mode         = s_tuser;
    assign weight_index = s_tdata[dldn_pkg::INDEX_W-1:0];
    assign data_value   = s_tdata[dldn_pkg::INDEX_W +: dldn_pkg::SAMPLE_W];

    assign s_tready = idle;
    assign accept   = s_tvalid & s_tready;
    assign start    = accept & (mode == dldn_pkg::MODE_SAMPLE);
    assign w1_wr_en = accept & (mode == dldn_pkg::MODE_W1_WRITE)
                    & (32'(weight_index) < W1_DEPTH);
    assign w2_wr_en = accept & (mode == dldn_pkg::MODE_W2_WRITE)
                    & (32'(weight_index) < W2_DEPTH);
    assign hid_wr_en = result_valid & !result_layer2;
    assign out_load  = result_valid & result_layer2;
    assign out_free  = !out_valid_reg;

    dldn_seq #(
        .TAPS         (TAPS),
        .HIDDEN_UNITS (HIDDEN_UNITS),
        .OUTPUT_UNITS (OUTPUT_UNITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .mac_busy    (mac_busy),
        .out_free    (out_free),
        .idle        (idle),
        .tap_wr_addr (tap_wr_addr),
        .tap_rd_addr (tap_rd_addr),
        .w1_rd_addr  (w1_rd_addr),
        .hid_rd_addr (hid_rd_addr),
        .w2_rd_addr  (w2_rd_addr),
        .issue_ctrl  (issue_ctrl),
        .issue_unit  (issue_unit)
    );

    dldn_ram #(
        .WIDTH (dldn_pkg::SAMPLE_W),
        .DEPTH (TAPS)
    ) u_tap_ram (
        .aclk    (aclk),
        .wr_en   (start),
        .wr_addr (tap_wr_addr),
        .wr_data (data_value),
        .rd_addr (tap_rd_addr),
        .rd_data (tap_data)
    );

    dldn_ram #(
        .WIDTH (dldn_pkg::SAMPLE_W),
        .DEPTH (W1_DEPTH)
    ) u_w1_ram (
        .aclk    (aclk),
        .wr_en   (w1_wr_en),
        .wr_addr (W1_AW'(weight_index)),
        .wr_data (data_value),
        .rd_addr (w1_rd_addr),
        .rd_data (w1_data)
    );

    dldn_ram #(
        .WIDTH (dldn_pkg::SAMPLE_W),
        .DEPTH (W2_DEPTH)
    ) u_w2_ram (
        .aclk    (aclk),
        .wr_en   (w2_wr_en),
        .wr_addr (W2_AW'(weight_index)),
        .wr_data (data_value),
        .rd_addr (w2_rd_addr),
        .rd_data (w2_data)
    );

    dldn_ram #(
        .WIDTH (ACT_W),
        .DEPTH (HIDDEN_UNITS)
    ) u_hid_ram (
        .aclk    (aclk),
        .wr_en   (hid_wr_en),
        .wr_addr (result_unit[HID_AW-1:0]),
        .wr_data (result_value),
        .rd_addr (hid_rd_addr),
        .rd_data (hid_data)
    );

    dldn_mac #(
        .FRAC_BITS (FRAC_BITS),
        .UNIT_W    (UNIT_W)
    ) u_mac (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .issue_ctrl    (issue_ctrl),
        .issue_unit    (issue_unit),
        .tap_data      (tap_data),
        .w1_data       (w1_data),
        .hid_data      (hid_data),
        .w2_data       (w2_data),
        .busy          (mac_busy),
        .result_valid  (result_valid),
        .result_layer2 (result_layer2),
        .result_unit   (result_unit),
        .result_value  (result_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            priority if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_index_reg <= result_unit[dldn_pkg::OUT_INDEX_W-1:0];
            out_value_reg <= dldn_pkg::OUT_VALUE_W'(result_value);
            out_last_reg  <= (result_unit == UNIT_W'(OUTPUT_UNITS - 1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dldn_pkg::M_TDATA_W'({out_value_reg, out_index_reg});
    assign m_tlast  = out_last_reg;

endmodule
